@@ hdl/lfa_pkg.sv @@
package lfa_pkg;

   // Beat payloads
   typedef struct packed {
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic [31:0] grain_radius;
      logic [31:0] surface_potential;
      logic [31:0] grain_mass;
   } req_type;

   typedef struct packed {
      logic [31:0] acc_x;
      logic [31:0] acc_y;
      logic [31:0] acc_z;
   } rsp_type;

   localparam int CSR_AW = 3;

   typedef enum logic [CSR_AW-1:0] {
      REG_ETEMP = 3'd0,
      REG_EX    = 3'd1,
      REG_EY    = 3'd2,
      REG_EZ    = 3'd3,
      REG_BX    = 3'd4,
      REG_BY    = 3'd5,
      REG_BZ    = 3'd6
   } csr_idx_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_ADD = 1'b1
   } fop_type;

   localparam int MUL_LAT   = 3;
   localparam int ADD_LAT   = 4;
   localparam int DIV_QBITS = 26;
   localparam int DIV_LAT   = DIV_QBITS + 3;
   localparam int TOTAL_LAT = 4 * MUL_LAT + DIV_LAT;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   // -4*pi*eps0*kB/e in binary32
   localparam logic [31:0] CHARGE_K  = 32'hA82C_B933;

   // Unpacked operand: effective exponent, significand with hidden bit
   typedef struct packed {
      logic        sgn;
      logic [7:0]  ex;
      logic [23:0] man;
      logic        nan;
      logic        inf;
      logic        zero;
   } fp_type;

   // Value = man * 2^(ex - 47) before normalizing, 1.f * 2^ex after
   typedef struct packed {
      logic               sgn;
      logic               nan;
      logic               inf;
      logic signed [10:0] ex;
      logic [47:0]        man;
      logic               stk;
   } nrm_type;

   function automatic fp_type fp_unpack(input logic [31:0] x);
      fp_type      u;
      logic [7:0]  e;
      logic [22:0] f;
      e      = x[30:23];
      f      = x[22:0];
      u.sgn  = x[31];
      u.ex   = (e == 8'd0) ? 8'd1 : e;
      u.man  = {(e != 8'd0), f};
      u.nan  = (e == 8'hFF) && (f != 23'd0);
      u.inf  = (e == 8'hFF) && (f == 23'd0);
      u.zero = (e == 8'd0) && (f == 23'd0);
      return u;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] x);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (x[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   function automatic nrm_type nrm_shift(input nrm_type x);
      nrm_type    y;
      logic [5:0] lz;
      lz    = lzc48(x.man);
      y     = x;
      y.man = x.man << lz;
      y.ex  = x.ex - 11'(lz);
      return y;
   endfunction

   // Round to nearest even and pack, including the subnormal range
   function automatic logic [31:0] nrm_round(input nrm_type x);
      logic signed [11:0] be;
      logic [5:0]         sh;
      logic [97:0]        t;
      logic [23:0]        kept;
      logic               g;
      logic               st;
      logic               inc;
      logic [24:0]        kr;
      logic [7:0]         base;
      logic [30:0]        sum;
      logic [31:0]        res;
      be = $signed({x.ex[10], x.ex}) + 12'sd127;
      if (be >= 12'sd1) begin
         sh = 6'd24;
      end else if (be < -12'sd25) begin
         sh = 6'd50;
      end else begin
         sh = 6'(12'sd25 - be);
      end
      t    = {x.man, 50'd0} >> sh;
      kept = t[73:50];
      g    = t[49];
      st   = (|t[48:0]) | x.stk;
      inc  = g & (st | kept[0]);
      kr   = {1'b0, kept} + 25'(inc);
      base = (be >= 12'sd1) ? 8'(be - 12'sd1) : 8'd0;
      sum  = {base, 23'd0} + 31'(kr);
      if (x.nan) begin
         res = CANON_NAN;
      end else if (x.inf) begin
         res = {x.sgn, 8'hFF, 23'd0};
      end else if (x.man == 48'd0) begin
         res = {x.sgn, 31'd0};
      end else if ((be >= 12'sd255) || (sum[30:23] == 8'hFF)) begin
         res = {x.sgn, 8'hFF, 23'd0};
      end else begin
         res = {x.sgn, sum};
      end
      return res;
   endfunction

endpackage

@@ hdl/lfa_fop.sv @@
module lfa_fop #(
   parameter lfa_pkg::fop_type OP = lfa_pkg::OP_MUL
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        out_vld,
   output logic [31:0] y
);

   generate
      if (OP == lfa_pkg::OP_MUL) begin : g_mul
         localparam int LAT = lfa_pkg::MUL_LAT;
         logic [LAT-1:0]   vld_ff;
         lfa_pkg::nrm_type s1_ff, s1_in, s2_ff, s2_in;
         logic [31:0]      y_ff, y_in;

         always_comb begin
            lfa_pkg::fp_type ua;
            lfa_pkg::fp_type ub;
            ua        = lfa_pkg::fp_unpack(a);
            ub        = lfa_pkg::fp_unpack(b);
            s1_in.sgn = ua.sgn ^ ub.sgn;
            s1_in.nan = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
            s1_in.inf = ua.inf | ub.inf;
            s1_in.ex  = 11'(ua.ex) + 11'(ub.ex) - 11'd253;
            s1_in.man = ua.man * ub.man;
            s1_in.stk = 1'b0;
            s2_in     = lfa_pkg::nrm_shift(s1_ff);
            y_in      = lfa_pkg::nrm_round(s2_ff);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff <= '0;
            end else begin
               vld_ff <= {vld_ff[LAT-2:0], in_vld};
            end
         end

         always_ff @(posedge clock) begin
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            y_ff  <= y_in;
         end

         assign out_vld = vld_ff[LAT-1];
         assign y       = y_ff;
      end else begin : g_add
         localparam int LAT = lfa_pkg::ADD_LAT;
         typedef struct packed {
            logic        sgn;
            logic        zsgn;
            logic        sub;
            logic        nan;
            logic        inf;
            logic        isgn;
            logic [7:0]  ex;
            logic [23:0] mbig;
            logic [23:0] msml;
            logic [7:0]  dif;
         } add_s1_type;

         logic [LAT-1:0]   vld_ff;
         add_s1_type       s1_ff, s1_in;
         lfa_pkg::nrm_type s2_ff, s2_in, s3_ff, s3_in;
         logic [31:0]      y_ff, y_in;

         always_comb begin
            lfa_pkg::fp_type ua;
            lfa_pkg::fp_type ub;
            lfa_pkg::fp_type big;
            lfa_pkg::fp_type sml;
            ua = lfa_pkg::fp_unpack(a);
            ub = lfa_pkg::fp_unpack(b);
            if (a[30:0] >= b[30:0]) begin
               big = ua;
               sml = ub;
            end else begin
               big = ub;
               sml = ua;
            end
            s1_in.sgn  = big.sgn;
            s1_in.zsgn = ua.sgn & ub.sgn;
            s1_in.sub  = ua.sgn ^ ub.sgn;
            s1_in.nan  = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sgn ^ ub.sgn));
            s1_in.inf  = ua.inf | ub.inf;
            s1_in.isgn = ua.inf ? ua.sgn : ub.sgn;
            s1_in.ex   = big.ex;
            s1_in.mbig = big.man;
            s1_in.msml = sml.man;
            s1_in.dif  = big.ex - sml.ex;
         end

         // Align the smaller operand, jam lost bits into the LSB, then add or subtract
         always_comb begin
            logic [5:0]  ds;
            logic [95:0] t;
            logic [47:0] al;
            logic [47:0] bw;
            logic [47:0] sum;
            ds  = (s1_ff.dif > 8'd48) ? 6'd48 : s1_ff.dif[5:0];
            t   = {1'b0, s1_ff.msml, 23'd0, 48'd0} >> ds;
            al  = t[95:48] | {47'd0, (|t[47:0])};
            bw  = {1'b0, s1_ff.mbig, 23'd0};
            sum = s1_ff.sub ? (bw - al) : (bw + al);
            s2_in.nan = s1_ff.nan;
            s2_in.inf = s1_ff.inf;
            if (s1_ff.inf) begin
               s2_in.sgn = s1_ff.isgn;
            end else if (sum == 48'd0) begin
               s2_in.sgn = s1_ff.zsgn;
            end else begin
               s2_in.sgn = s1_ff.sgn;
            end
            s2_in.ex  = 11'(s1_ff.ex) - 11'd126;
            s2_in.man = sum;
            s2_in.stk = 1'b0;
            s3_in     = lfa_pkg::nrm_shift(s2_ff);
            y_in      = lfa_pkg::nrm_round(s3_ff);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff <= '0;
            end else begin
               vld_ff <= {vld_ff[LAT-2:0], in_vld};
            end
         end

         always_ff @(posedge clock) begin
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            s3_ff <= s3_in;
            y_ff  <= y_in;
         end

         assign out_vld = vld_ff[LAT-1];
         assign y       = y_ff;
      end
   endgenerate

endmodule

@@ hdl/lfa_fdiv.sv @@
module lfa_fdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        out_vld,
   output logic [31:0] y
);

   localparam int QB  = lfa_pkg::DIV_QBITS;
   localparam int LAT = lfa_pkg::DIV_LAT;

   typedef struct packed {
      logic               sgn;
      logic               nan;
      logic               inf;
      logic               zero;
      logic signed [10:0] ex;
      logic [23:0]        den;
      logic [24:0]        rem;
      logic [QB-1:0]      quo;
   } div_stage_type;

   // One restoring step: one quotient bit per stage
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic          ge;
      logic [24:0]   d;
      ge    = s.rem >= {1'b0, s.den};
      d     = ge ? (s.rem - {1'b0, s.den}) : s.rem;
      r     = s;
      r.rem = {d[23:0], 1'b0};
      r.quo = {s.quo[QB-2:0], ge};
      return r;
   endfunction

   logic [LAT-1:0]   vld_ff;
   div_stage_type    stg_ff [QB+1];
   div_stage_type    stg_in [QB+1];
   lfa_pkg::nrm_type nrm_ff, nrm_in;
   logic [31:0]      y_ff, y_in;

   always_comb begin
      lfa_pkg::fp_type  ua;
      lfa_pkg::fp_type  ub;
      logic [5:0]       lza;
      logic [5:0]       lzb;
      lfa_pkg::nrm_type n;
      div_stage_type    last;
      ua  = lfa_pkg::fp_unpack(a);
      ub  = lfa_pkg::fp_unpack(b);
      lza = lfa_pkg::lzc48({ua.man, 24'd0});
      lzb = lfa_pkg::lzc48({ub.man, 24'd0});
      stg_in[0].sgn  = ua.sgn ^ ub.sgn;
      stg_in[0].nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
      stg_in[0].inf  = ua.inf | ub.zero;
      stg_in[0].zero = ua.zero | ub.inf;
      stg_in[0].ex   = 11'(ua.ex) - 11'(lza) - 11'(ub.ex) + 11'(lzb);
      stg_in[0].den  = ub.man << lzb;
      stg_in[0].rem  = {1'b0, ua.man << lza};
      stg_in[0].quo  = '0;
      for (int k = 0; k < QB; k++) begin
         stg_in[k+1] = div_step(stg_ff[k]);
      end
      last  = stg_ff[QB];
      n.sgn = last.sgn;
      n.nan = last.nan;
      n.inf = last.inf;
      n.ex  = last.ex;
      n.man = last.zero ? 48'd0 : {last.quo, (48 - QB)'(0)};
      n.stk = ~last.zero & (last.rem != 25'd0);
      nrm_in = lfa_pkg::nrm_shift(n);
      y_in   = lfa_pkg::nrm_round(nrm_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         stg_ff[k] <= stg_in[k];
      end
      nrm_ff <= nrm_in;
      y_ff   <= y_in;
   end

   assign out_vld = vld_ff[LAT-1];
   assign y       = y_ff;

endmodule

@@ hdl/lorentz_force_acceleration_top.sv @@
// Every accepted start beat comes back as a result with its rsp_valid strobe.
// Throughput: one beat per cycle, set by the fully pipelined binary32 units;
//   the 26-stage restoring divider for charge over mass is the longest path.
// Reset: synchronous, active high; clears the CSRs to +0.0 and drops every
//   beat in flight. busy is high only during reset.
// The receiver cannot stall: each result shows for exactly one cycle.
module lorentz_force_acceleration_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lfa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output lfa_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [lfa_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [31:0]                   csr_wdata
);

   // Align side inputs with the charge chain and the field sums with the ratio
   localparam int POT_DLY  = 2 * lfa_pkg::MUL_LAT;
   localparam int MASS_DLY = 3 * lfa_pkg::MUL_LAT;
   localparam int SUM_DLY  = 2 * lfa_pkg::MUL_LAT + lfa_pkg::DIV_LAT
                             - 2 * lfa_pkg::ADD_LAT;

   logic        acc_beat;

   // Configuration registers
   logic [31:0] etemp_ff, ex_ff, ey_ff, ez_ff, bx_ff, by_ff, bz_ff;

   // Charge chain
   logic [31:0] q0_y, q1_y, q2_y, ratio_y;
   logic        q0_vld, q1_vld, q2_vld, ratio_vld;

   // Cross product and field sums
   logic [31:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
   logic        prod_vld;
   logic [31:0] c_x, c_y, c_z;
   logic        cross_vld;
   logic [31:0] s_x, s_y, s_z;

   // Delay lines
   logic [31:0] pot_dly_ff  [POT_DLY];
   logic [31:0] pot_dly_in  [POT_DLY];
   logic [31:0] mass_dly_ff [MASS_DLY];
   logic [31:0] mass_dly_in [MASS_DLY];
   logic [95:0] sum_dly_ff  [SUM_DLY];
   logic [95:0] sum_dly_in  [SUM_DLY];

   logic [31:0] acc_x, acc_y, acc_z;

   // The pipeline takes a beat every cycle; hold off only while in reset
   assign busy     = reset;
   assign acc_beat = start & ~busy;

   // CSR writes; drop writes to unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         etemp_ff <= '0;
         ex_ff    <= '0;
         ey_ff    <= '0;
         ez_ff    <= '0;
         bx_ff    <= '0;
         by_ff    <= '0;
         bz_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            lfa_pkg::REG_ETEMP: etemp_ff <= csr_wdata;
            lfa_pkg::REG_EX:    ex_ff    <= csr_wdata;
            lfa_pkg::REG_EY:    ey_ff    <= csr_wdata;
            lfa_pkg::REG_EZ:    ez_ff    <= csr_wdata;
            lfa_pkg::REG_BX:    bx_ff    <= csr_wdata;
            lfa_pkg::REG_BY:    by_ff    <= csr_wdata;
            lfa_pkg::REG_BZ:    bz_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the delay lines every cycle
   always_comb begin
      pot_dly_in[0]  = req_data.surface_potential;
      mass_dly_in[0] = req_data.grain_mass;
      sum_dly_in[0]  = {s_x, s_y, s_z};
      for (int i = 1; i < POT_DLY; i++) begin
         pot_dly_in[i] = pot_dly_ff[i-1];
      end
      for (int i = 1; i < MASS_DLY; i++) begin
         mass_dly_in[i] = mass_dly_ff[i-1];
      end
      for (int i = 1; i < SUM_DLY; i++) begin
         sum_dly_in[i] = sum_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      pot_dly_ff  <= pot_dly_in;
      mass_dly_ff <= mass_dly_in;
      sum_dly_ff  <= sum_dly_in;
   end

   // Charge: ((K * radius) * Te) * potential, then divide by mass
   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_q0 (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(lfa_pkg::CHARGE_K), .b(req_data.grain_radius),
      .out_vld(q0_vld), .y(q0_y));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_q1 (
      .clock(clock), .reset(reset), .in_vld(q0_vld),
      .a(q0_y), .b(etemp_ff),
      .out_vld(q1_vld), .y(q1_y));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_q2 (
      .clock(clock), .reset(reset), .in_vld(q1_vld),
      .a(q1_y), .b(pot_dly_ff[POT_DLY-1]),
      .out_vld(q2_vld), .y(q2_y));

   lfa_fdiv u_ratio (
      .clock(clock), .reset(reset), .in_vld(q2_vld),
      .a(q2_y), .b(mass_dly_ff[MASS_DLY-1]),
      .out_vld(ratio_vld), .y(ratio_y));

   // v x B partial products, all six in parallel
   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_p_yz (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(req_data.vel_y), .b(bz_ff), .out_vld(prod_vld), .y(p_yz));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_p_zy (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(req_data.vel_z), .b(by_ff), .out_vld(), .y(p_zy));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_p_zx (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(req_data.vel_z), .b(bx_ff), .out_vld(), .y(p_zx));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_p_xz (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(req_data.vel_x), .b(bz_ff), .out_vld(), .y(p_xz));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_p_xy (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(req_data.vel_x), .b(by_ff), .out_vld(), .y(p_xy));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_p_yx (
      .clock(clock), .reset(reset), .in_vld(acc_beat),
      .a(req_data.vel_y), .b(bx_ff), .out_vld(), .y(p_yx));

   // Subtract by flipping the sign of the second term
   lfa_fop #(.OP(lfa_pkg::OP_ADD)) u_c_x (
      .clock(clock), .reset(reset), .in_vld(prod_vld),
      .a(p_yz), .b({~p_zy[31], p_zy[30:0]}), .out_vld(cross_vld), .y(c_x));

   lfa_fop #(.OP(lfa_pkg::OP_ADD)) u_c_y (
      .clock(clock), .reset(reset), .in_vld(prod_vld),
      .a(p_zx), .b({~p_xz[31], p_xz[30:0]}), .out_vld(), .y(c_y));

   lfa_fop #(.OP(lfa_pkg::OP_ADD)) u_c_z (
      .clock(clock), .reset(reset), .in_vld(prod_vld),
      .a(p_xy), .b({~p_yx[31], p_yx[30:0]}), .out_vld(), .y(c_z));

   // E + v x B
   lfa_fop #(.OP(lfa_pkg::OP_ADD)) u_s_x (
      .clock(clock), .reset(reset), .in_vld(cross_vld),
      .a(ex_ff), .b(c_x), .out_vld(), .y(s_x));

   lfa_fop #(.OP(lfa_pkg::OP_ADD)) u_s_y (
      .clock(clock), .reset(reset), .in_vld(cross_vld),
      .a(ey_ff), .b(c_y), .out_vld(), .y(s_y));

   lfa_fop #(.OP(lfa_pkg::OP_ADD)) u_s_z (
      .clock(clock), .reset(reset), .in_vld(cross_vld),
      .a(ez_ff), .b(c_z), .out_vld(), .y(s_z));

   // Scale by charge over mass; the delayed sums meet the ratio here
   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_a_x (
      .clock(clock), .reset(reset), .in_vld(ratio_vld),
      .a(sum_dly_ff[SUM_DLY-1][95:64]), .b(ratio_y), .out_vld(rsp_valid), .y(acc_x));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_a_y (
      .clock(clock), .reset(reset), .in_vld(ratio_vld),
      .a(sum_dly_ff[SUM_DLY-1][63:32]), .b(ratio_y), .out_vld(), .y(acc_y));

   lfa_fop #(.OP(lfa_pkg::OP_MUL)) u_a_z (
      .clock(clock), .reset(reset), .in_vld(ratio_vld),
      .a(sum_dly_ff[SUM_DLY-1][31:0]), .b(ratio_y), .out_vld(), .y(acc_z));

   assign rsp_data = '{acc_x: acc_x, acc_y: acc_y, acc_z: acc_z};

endmodule

@@ hdl/lfa_checker.sv @@
module lfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lfa_pkg::rsp_type rsp_data
);

   localparam int LAT = lfa_pkg::TOTAL_LAT;

   a_busy_only_in_reset: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy high outside reset");

   a_beat_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted beat produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LAT))
      else $error("result without an accepted beat");

   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.acc_x[30:23] != 8'hFF) || (rsp_data.acc_x[22:0] == 23'd0) ||
          (rsp_data.acc_x == lfa_pkg::CANON_NAN)) &&
         ((rsp_data.acc_y[30:23] != 8'hFF) || (rsp_data.acc_y[22:0] == 23'd0) ||
          (rsp_data.acc_y == lfa_pkg::CANON_NAN)) &&
         ((rsp_data.acc_z[30:23] != 8'hFF) || (rsp_data.acc_z[22:0] == 23'd0) ||
          (rsp_data.acc_z == lfa_pkg::CANON_NAN)))
      else $error("non-canonical NaN on result");

endmodule

bind lorentz_force_acceleration_top lfa_checker u_lfa_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);

@@ dv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W      = lfa_pkg::CSR_AW;
   localparam int LATENCY     = 41;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_CSR     = 7;
   // Index 7 has no register behind it; a write there must change nothing.
   localparam logic [ADDR_W-1:0] SPARE_IDX = 3'd7;

   localparam logic [31:0] POS_ZERO = 32'h0000_0000;
   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
   localparam logic [31:0] POS_INF  = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
   localparam logic [31:0] MAX_NORM = 32'h7F7F_FFFF;
   localparam logic [31:0] MIN_NORM = 32'h0080_0000;
   localparam logic [31:0] MIN_SUB  = 32'h0000_0001;
   localparam logic [31:0] MAX_SUB  = 32'h007F_FFFF;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE      = 32'h3F80_0000;
   localparam logic [31:0] MINUS_TWO = 32'hC000_0000;

   // DUT-facing signals; those the bench drives are known from time zero
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   lfa_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   lfa_pkg::rsp_type rsp_data;
   logic             csr_we    = 1'b0;
   logic [ADDR_W-1:0] csr_addr  = '0;
   logic [31:0]       csr_wdata = '0;

   lorentz_force_acceleration_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the field and temperature registers
   logic [31:0] field_regs [NUM_CSR];

   lfa_pkg::req_type pending_grains [$];
   lfa_pkg::rsp_type accel_expected [$];
   logic    beat_taken   = 1'b0;
   logic    hold_sender  = 1'b0;
   int      idle_pct     = 12;
   int      cycle_count  = 0;
   int      grains_sent  = 0;
   int      accels_seen  = 0;
   int      error_count  = 0;
   logic [31:0] charge_k;

   // ---------------------------------------------------------------------
   // binary32 arithmetic done in double precision. Products of two binary32
   // values are exact in double, and for add, sub and divide one rounding to
   // double followed by one to binary32 gives the correctly rounded result.
   // ---------------------------------------------------------------------
   function automatic real f32_to_real(input logic [31:0] x);
      logic [63:0] d;
      logic [7:0]  e;
      logic [22:0] f;
      logic [51:0] fr;
      int          msb;
      e = x[30:23];
      f = x[22:0];
      if (e == 8'hFF) begin
         d = {x[31], 11'h7FF, f, 29'd0};
      end else if (e == 8'd0) begin
         if (f == 23'd0) begin
            d = {x[31], 63'd0};
         end else begin
            // subnormal: renormalize around the leading one
            msb = 0;
            for (int i = 0; i < 23; i++) begin
               if (f[i]) msb = i;
            end
            fr = 52'(64'(f) << (52 - msb));
            d  = {x[31], 11'(msb - 149 + 1023), fr};
         end
      end else begin
         d = {x[31], 11'(int'(e) - 127 + 1023), f, 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   function automatic logic [31:0] real_to_f32(input real r);
      logic [63:0] d;
      logic [10:0] ed;
      logic [63:0] m;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] packed_val;
      int          be;
      int          sh;
      d  = $realtobits(r);
      ed = d[62:52];
      if (ed == 11'h7FF) begin
         return (d[51:0] != 52'd0) ? lfa_pkg::CANON_NAN : {d[63], 8'hFF, 23'd0};
      end
      // anything in the double subnormal range is far below half an ulp
      if (ed == 11'd0) begin
         return {d[63], 31'd0};
      end
      be = int'(ed) - 1023 + 127;
      if (be >= 255) begin
         return {d[63], 8'hFF, 23'd0};
      end
      m  = {11'd0, 1'b1, d[51:0]};
      sh = (be >= 1) ? 29 : 30 - be;
      if (sh > 60) sh = 60;
      kept = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if ((rem > half) || ((rem == half) && kept[0])) begin
         kept = kept + 64'd1;
      end
      packed_val = (64'((be >= 1) ? be - 1 : 0) << 23) + kept;
      if (packed_val >= 64'h7F80_0000) begin
         return {d[63], 8'hFF, 23'd0};
      end
      return {d[63], packed_val[30:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      return real_to_f32(f32_to_real(a) * f32_to_real(b));
   endfunction

   function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b);
      return real_to_f32(f32_to_real(a) - f32_to_real(b));
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      return real_to_f32(f32_to_real(a) + f32_to_real(b));
   endfunction

   function automatic logic f32_is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // Charge over mass; a zero mass gives an infinity or NaN per IEEE rules
   function automatic logic [31:0] charge_ratio(input logic [31:0] q, input logic [31:0] m);
      if (m[30:0] == 31'd0) begin
         if ((q[30:0] == 31'd0) || f32_is_nan(q)) return lfa_pkg::CANON_NAN;
         return {q[31] ^ m[31], 8'hFF, 23'd0};
      end
      return real_to_f32(f32_to_real(q) / f32_to_real(m));
   endfunction

   function automatic lfa_pkg::rsp_type predict_accel(input lfa_pkg::req_type g);
      lfa_pkg::rsp_type a;
      logic [31:0]      q;
      logic [31:0]      ratio;
      logic [31:0]      cx;
      logic [31:0]      cy;
      logic [31:0]      cz;
      q = f32_mul(charge_k, g.grain_radius);
      q = f32_mul(q, field_regs[lfa_pkg::REG_ETEMP]);
      q = f32_mul(q, g.surface_potential);
      ratio = charge_ratio(q, g.grain_mass);
      // v x B, one rounding per product and per difference
      cx = f32_sub(f32_mul(g.vel_y, field_regs[lfa_pkg::REG_BZ]),
                   f32_mul(g.vel_z, field_regs[lfa_pkg::REG_BY]));
      cy = f32_sub(f32_mul(g.vel_z, field_regs[lfa_pkg::REG_BX]),
                   f32_mul(g.vel_x, field_regs[lfa_pkg::REG_BZ]));
      cz = f32_sub(f32_mul(g.vel_x, field_regs[lfa_pkg::REG_BY]),
                   f32_mul(g.vel_y, field_regs[lfa_pkg::REG_BX]));
      a.acc_x = f32_mul(f32_add(field_regs[lfa_pkg::REG_EX], cx), ratio);
      a.acc_y = f32_mul(f32_add(field_regs[lfa_pkg::REG_EY], cy), ratio);
      a.acc_z = f32_mul(f32_add(field_regs[lfa_pkg::REG_EZ], cz), ratio);
      return a;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present the head of the pending queue at the falling edge and
   // drop it once the rising edge has taken it.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (beat_taken) begin
         beat_taken = 1'b0;
         void'(pending_grains.pop_front());
      end
      if (!reset && (pending_grains.size() != 0) && !hold_sender &&
          ($urandom_range(0, 99) >= idle_pct)) begin
         start    <= 1'b1;
         req_data <= pending_grains[0];
      end else begin
         start    <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on every accepted start beat, check every result beat
   // against the oldest prediction, and watch the cycle budget.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, accel_expected.size());
         $display("status: fail");
         $finish;
      end else begin
         if (!reset && start && !busy) begin
            accel_expected.push_back(predict_accel(req_data));
            beat_taken = 1'b1;
            grains_sent++;
         end
         if (!reset && rsp_valid) begin
            accels_seen++;
            if (accel_expected.size() == 0) begin
               $error("result beat with nothing expected: %h %h %h",
                      rsp_data.acc_x, rsp_data.acc_y, rsp_data.acc_z);
               error_count++;
            end else begin
               lfa_pkg::rsp_type want;
               want = accel_expected.pop_front();
               if (rsp_data.acc_x !== want.acc_x) begin
                  $error("acc_x expected %h actual %h", want.acc_x, rsp_data.acc_x);
                  error_count++;
               end
               if (rsp_data.acc_y !== want.acc_y) begin
                  $error("acc_y expected %h actual %h", want.acc_y, rsp_data.acc_y);
                  error_count++;
               end
               if (rsp_data.acc_z !== want.acc_z) begin
                  $error("acc_z expected %h actual %h", want.acc_z, rsp_data.acc_z);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly plausible magnitudes around 2^(center-127), with a share of
   // zeros, infinities, NaNs, subnormals, range limits and raw bit patterns.
   function automatic logic [31:0] pick_f32(input int center);
      logic        s;
      logic [22:0] mant;
      s    = 1'($urandom_range(0, 1));
      mant = 23'($urandom);
      case ($urandom_range(0, 24))
         0: return {s, 31'd0};
         1: return {s, 8'hFF, 23'd0};
         2: return {s, 8'hFF, (mant == 23'd0) ? 23'd1 : mant};
         3: return {s, 8'h00, mant};
         4: return {s, MAX_NORM[30:0]};
         5: return {s, MIN_NORM[30:0]};
         6, 7: return 32'($urandom);
         default: return {s, 8'(center + $urandom_range(0, 8) - 4), mant};
      endcase
   endfunction

   function automatic lfa_pkg::req_type random_grain();
      lfa_pkg::req_type g;
      g.vel_x             = pick_f32(130);
      g.vel_y             = pick_f32(130);
      g.vel_z             = pick_f32(130);
      g.grain_radius      = pick_f32(107);
      g.surface_potential = pick_f32(128);
      g.grain_mass        = pick_f32(77);
      return g;
   endfunction

   function automatic lfa_pkg::req_type make_grain(input logic [31:0] vx,
                                                   input logic [31:0] vy,
                                                   input logic [31:0] vz,
                                                   input logic [31:0] rad,
                                                   input logic [31:0] pot,
                                                   input logic [31:0] mass);
      lfa_pkg::req_type g;
      g.vel_x             = vx;
      g.vel_y             = vy;
      g.vel_z             = vz;
      g.grain_radius      = rad;
      g.surface_potential = pot;
      g.grain_mass        = mass;
      return g;
   endfunction

   // Hold until the pending queue is empty and all results are in, then let
   // the pipeline settle before touching the registers.
   task automatic drain();
      while ((pending_grains.size() != 0) || (accel_expected.size() != 0) || start) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Write all seven registers back to back, plus one write to the spare index.
   task automatic load_fields(input logic [31:0] vals [NUM_CSR]);
      for (int i = 0; i < NUM_CSR; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= ADDR_W'(i);
         csr_wdata <= vals[i];
         field_regs[i] = vals[i];
      end
      @(negedge clock);
      csr_addr  <= SPARE_IDX;
      csr_wdata <= 32'($urandom);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic void physical_fields(output logic [31:0] vals [NUM_CSR]);
      vals[lfa_pkg::REG_ETEMP] = {1'b0, 8'(140 + $urandom_range(0, 3) - 2), 23'($urandom)};
      vals[lfa_pkg::REG_EX]    = {1'($urandom_range(0, 1)), 8'(137 - $urandom_range(0, 4)),
                                  23'($urandom)};
      vals[lfa_pkg::REG_EY]    = {1'($urandom_range(0, 1)), 8'(137 - $urandom_range(0, 4)),
                                  23'($urandom)};
      vals[lfa_pkg::REG_EZ]    = {1'($urandom_range(0, 1)), 8'(137 - $urandom_range(0, 4)),
                                  23'($urandom)};
      vals[lfa_pkg::REG_BX]    = {1'($urandom_range(0, 1)), 8'(127 - $urandom_range(0, 4)),
                                  23'($urandom)};
      vals[lfa_pkg::REG_BY]    = {1'($urandom_range(0, 1)), 8'(127 - $urandom_range(0, 4)),
                                  23'($urandom)};
      vals[lfa_pkg::REG_BZ]    = {1'($urandom_range(0, 1)), 8'(127 - $urandom_range(0, 4)),
                                  23'($urandom)};
   endfunction

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) begin
         pending_grains.push_back(random_grain());
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] vals [NUM_CSR];

      charge_k = real_to_f32(-9.5880763e-15);
      for (int i = 0; i < NUM_CSR; i++) field_regs[i] = POS_ZERO;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers still at reset: zero temperature, so no charge from any finite grain
      push_random(20);
      drain();

      // Directed grains under a plausible field setup
      physical_fields(vals);
      load_fields(vals);
      pending_grains.push_back(make_grain(POS_ZERO, NEG_ZERO, POS_ZERO, POS_ZERO, POS_ZERO,
                                          POS_ZERO));
      // zero mass with nonzero charge of either sign, with zero charge and with NaN charge
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h3580_0000, MINUS_TWO, POS_ZERO));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h3580_0000, ONE, NEG_ZERO));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h3580_0000, MINUS_TWO, NEG_ZERO));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, POS_ZERO, MINUS_TWO, POS_ZERO));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h7FC0_0001, ONE, POS_ZERO));
      // A NaN or an infinity in each operand position
      pending_grains.push_back(make_grain(32'h7FA0_0000, ONE, ONE, 32'h3580_0000, ONE,
                                          32'h2700_0000));
      pending_grains.push_back(make_grain(ONE, POS_INF, ONE, 32'h3580_0000, ONE, 32'h2700_0000));
      pending_grains.push_back(make_grain(ONE, ONE, NEG_INF, 32'h3580_0000, ONE, 32'h2700_0000));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, POS_INF, ONE, 32'h2700_0000));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h3580_0000, ALL_ONES, 32'h2700_0000));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h3580_0000, ONE, POS_INF));
      pending_grains.push_back(make_grain(ONE, ONE, ONE, 32'h3580_0000, ONE, 32'hFFC0_0000));
      // subnormal and range-limit operands, overflow and underflow of results
      pending_grains.push_back(make_grain(MIN_SUB, MAX_SUB, MIN_NORM, MIN_SUB, ONE, MIN_SUB));
      pending_grains.push_back(make_grain(MAX_NORM, MAX_NORM, MAX_NORM, MAX_NORM, MAX_NORM,
                                          MIN_SUB));
      pending_grains.push_back(make_grain(MIN_NORM, MIN_NORM, MIN_NORM, MIN_SUB, MIN_SUB,
                                          MAX_NORM));
      pending_grains.push_back(make_grain(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                          ALL_ONES));
      pending_grains.push_back(make_grain(32'hFF7F_FFFF, MAX_NORM, 32'h8080_0000, 32'h3580_0000,
                                          MINUS_TWO, 32'h2700_0000));
      pending_grains.push_back(make_grain(32'h4120_0000, 32'hC120_0000, 32'h4120_0000,
                                          32'h3580_0000, MINUS_TWO, 32'h2700_0000));
      drain();

      // Long random stretch with the usual idling; pause the sender midway
      // until every result has come back.
      physical_fields(vals);
      load_fields(vals);
      push_random(250);
      while (pending_grains.size() > 120) @(posedge clock);
      hold_sender = 1'b1;
      while (accel_expected.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      push_random(250);
      drain();

      // All registers NaN
      for (int i = 0; i < NUM_CSR; i++) vals[i] = ALL_ONES;
      load_fields(vals);
      push_random(80);
      drain();

      // Largest finite fields and temperature
      for (int i = 0; i < NUM_CSR; i++) vals[i] = MAX_NORM;
      vals[lfa_pkg::REG_BY] = 32'hFF7F_FFFF;
      load_fields(vals);
      push_random(80);
      drain();

      // Infinities and signed zeros
      vals[lfa_pkg::REG_ETEMP] = POS_INF;
      vals[lfa_pkg::REG_EX] = NEG_ZERO;
      vals[lfa_pkg::REG_EY] = NEG_INF;
      vals[lfa_pkg::REG_EZ] = POS_ZERO;
      vals[lfa_pkg::REG_BX] = POS_INF;
      vals[lfa_pkg::REG_BY] = NEG_ZERO;
      vals[lfa_pkg::REG_BZ] = MIN_SUB;
      load_fields(vals);
      push_random(80);
      drain();

      // Raw random register contents
      for (int i = 0; i < NUM_CSR; i++) vals[i] = 32'($urandom);
      load_fields(vals);
      push_random(200);
      drain();

      // Back-to-back beats with no sender idling at all
      idle_pct = 0;
      physical_fields(vals);
      load_fields(vals);
      push_random(400);
      drain();

      // Mixed idling again under a fresh plausible setup
      idle_pct = 12;
      physical_fields(vals);
      load_fields(vals);
      push_random(370);
      drain();

      $display("covered %0d grains and %0d result beats over nine register setups",
               grains_sent, accels_seen);
      $display("setups: reset, plausible, NaN, max finite, inf/zero, raw bits; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
